[rtl/pid_poi_pkg.sv]
// ----------------------------------------------------------------------------
// pid_poi_pkg
// Shared widths, defaults and register indexes for the PID controller block.
// ----------------------------------------------------------------------------
`default_nettype none

package pid_poi_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed field widths.
    localparam int GAIN_WIDTH      = 16;
    localparam int LIMIT_WIDTH     = 31;
    localparam int OUT_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 31;

    // Weight of the previous error in the second difference.
    localparam int DELTA_WEIGHT = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOOP_FORM      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_OUTPUT     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEGRAL_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P         = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I         = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D         = 3'd5;

    // Loop form codes.
    localparam logic FORM_POSITIONAL  = 1'b0;
    localparam logic FORM_INCREMENTAL = 1'b1;

endpackage

`default_nettype wire

[rtl/pid_position_or_incremental_top.sv]
// ----------------------------------------------------------------------------
// pid_position_or_incremental_top
// Fixed-point PID controller with positional and incremental loop forms.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one measured sample and one target. A beat
// is taken on a rising edge where in_valid is high and in_stall is low. The
// block forms error = target - measured and returns one control_out beat per
// input beat on the output channel, taken where out_valid is high and
// out_stall is low.
// The beat lands in an input register, then one pass of logic (three Q8.8
// gain multiplies, floor shift, sums and symmetric clamps) writes the result
// register and the controller state together. Throughput is one beat per
// cycle while out_stall is low; the limit is that single pass, since the
// error history, integral and previous output are all updated in it.
// When the receiver stalls, the result register holds its beat and the input
// register keeps the next one; in_stall rises only once both are full.
// Reset clears the configuration, the state and both valid flags. Any write
// to a known register index also clears error history, integral and previous
// output. Users must make writes while the block is idle; it does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_or_incremental_top #(
    parameter int SAMPLE_WIDTH   = pid_poi_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pid_poi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // Input channel.
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]           measured,
    input  wire logic signed [SAMPLE_WIDTH-1:0]           target,
    // Output channel.
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic signed [pid_poi_pkg::OUT_WIDTH-1:0]      control_out,
    // Configuration write port.
    input  wire logic                                     cfg_wr_en,
    input  wire logic [pid_poi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [pid_poi_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import pid_poi_pkg::*;

    // Error is one bit wider than a sample; the second difference two more.
    localparam int EW = SAMPLE_WIDTH + 1;
    localparam int DW = SAMPLE_WIDTH + 3;
    // Exact product of a gain and the widest difference.
    localparam int PW = GAIN_WIDTH + DW;
    // Sum width holds four terms of the wider of a product and a 32-bit value.
    localparam int SW = ((PW > OUT_WIDTH) ? PW : OUT_WIDTH) + 3;

    // Configuration registers.
    logic                           loop_form_reg;
    logic [LIMIT_WIDTH-1:0]         max_output_reg;
    logic [LIMIT_WIDTH-1:0]         integral_limit_reg;
    logic signed [GAIN_WIDTH-1:0]   gain_p_reg;
    logic signed [GAIN_WIDTH-1:0]   gain_i_reg;
    logic signed [GAIN_WIDTH-1:0]   gain_d_reg;
    logic                           cfg_hit;

    // Controller state.
    logic signed [EW-1:0]           err_prev_reg;
    logic signed [EW-1:0]           err_prev2_reg;
    logic signed [OUT_WIDTH-1:0]    integral_acc_reg;
    logic signed [OUT_WIDTH-1:0]    prev_output_reg;

    // Input register.
    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_measured_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_target_reg;

    logic                           in_take;
    logic                           advance;

    // Datapath.
    logic signed [EW-1:0]           err;
    logic signed [DW-1:0]           diff1;
    logic signed [DW-1:0]           diff2;
    logic signed [DW-1:0]           p_operand;
    logic signed [DW-1:0]           d_operand;
    logic signed [PW-1:0]           p_prod;
    logic signed [PW-1:0]           i_prod;
    logic signed [PW-1:0]           d_prod;
    logic signed [SW-1:0]           p_term;
    logic signed [SW-1:0]           i_term;
    logic signed [SW-1:0]           d_term;
    logic signed [SW-1:0]           i_pre_clamp;
    logic signed [SW-1:0]           i_clamped;
    logic signed [SW-1:0]           out_pre_clamp;
    logic signed [SW-1:0]           out_clamped;
    logic signed [SW-1:0]           ilim;
    logic signed [SW-1:0]           olim;
    logic signed [OUT_WIDTH-1:0]    result_next;
    logic signed [OUT_WIDTH-1:0]    integral_next;

    // Handshake: the result register frees up when empty or being taken,
    // and the input register moves on when it is empty or advancing.
    assign advance  = s1_valid_reg && (!out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_measured_reg <= measured;
            s1_target_reg   <= target;
        end
        if (advance)
        begin
            control_out <= result_next;
        end
    end

    // Error and its first and second differences.
    assign err   = EW'(s1_target_reg) - EW'(s1_measured_reg);
    assign diff1 = DW'(err) - DW'(err_prev_reg);
    assign diff2 = DW'(err) - DW'(err_prev_reg) * signed'(DW'(DELTA_WEIGHT))
                   + DW'(err_prev2_reg);

    // The proportional and derivative gains see different differences in
    // the two loop forms; the integral gain always sees the raw error.
    assign p_operand = (loop_form_reg == FORM_INCREMENTAL) ? diff1 : DW'(err);
    assign d_operand = (loop_form_reg == FORM_INCREMENTAL) ? diff2 : diff1;

    assign p_prod = PW'(gain_p_reg) * PW'(p_operand);
    assign i_prod = PW'(gain_i_reg) * PW'(err);
    assign d_prod = PW'(gain_d_reg) * PW'(d_operand);

    // Arithmetic shift right rounds toward minus infinity.
    assign p_term = SW'(p_prod >>> GAIN_FRAC_BITS);
    assign i_term = SW'(i_prod >>> GAIN_FRAC_BITS);
    assign d_term = SW'(d_prod >>> GAIN_FRAC_BITS);

    assign ilim = signed'(SW'(integral_limit_reg));
    assign olim = signed'(SW'(max_output_reg));

    // Positional form clamps the running integral; incremental form clamps
    // only this sample's integral term.
    assign i_pre_clamp = (loop_form_reg == FORM_INCREMENTAL) ? i_term
                         : SW'(integral_acc_reg) + i_term;

    always_comb
    begin
        if (i_pre_clamp > ilim)
        begin
            i_clamped = ilim;
        end
        else if (i_pre_clamp < -ilim)
        begin
            i_clamped = -ilim;
        end
        else
        begin
            i_clamped = i_pre_clamp;
        end
    end

    assign out_pre_clamp = p_term + i_clamped + d_term
                           + ((loop_form_reg == FORM_INCREMENTAL)
                              ? SW'(prev_output_reg) : SW'(0));

    always_comb
    begin
        if (out_pre_clamp > olim)
        begin
            out_clamped = olim;
        end
        else if (out_pre_clamp < -olim)
        begin
            out_clamped = -olim;
        end
        else
        begin
            out_clamped = out_pre_clamp;
        end
    end

    assign result_next   = out_clamped[OUT_WIDTH-1:0];
    assign integral_next = (loop_form_reg == FORM_INCREMENTAL) ? integral_acc_reg
                           : i_clamped[OUT_WIDTH-1:0];

    // Only the six known indexes take effect and clear the state.
    always_comb
    begin
        case (cfg_index)
            REG_LOOP_FORM,
            REG_MAX_OUTPUT,
            REG_INTEGRAL_LIMIT,
            REG_GAIN_P,
            REG_GAIN_I,
            REG_GAIN_D: cfg_hit = cfg_wr_en;
            default:    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_form_reg      <= FORM_POSITIONAL;
            max_output_reg     <= '0;
            integral_limit_reg <= '0;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LOOP_FORM:      loop_form_reg      <= cfg_data[0];
                REG_MAX_OUTPUT:     max_output_reg     <= cfg_data[LIMIT_WIDTH-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
                REG_GAIN_P:         gain_p_reg         <= cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_I:         gain_i_reg         <= cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_D:         gain_d_reg         <= cfg_data[GAIN_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // State moves with each beat that enters the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_prev_reg     <= '0;
            err_prev2_reg    <= '0;
            integral_acc_reg <= '0;
            prev_output_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            err_prev_reg     <= '0;
            err_prev2_reg    <= '0;
            integral_acc_reg <= '0;
            prev_output_reg  <= '0;
        end
        else if (advance)
        begin
            err_prev_reg     <= err;
            err_prev2_reg    <= err_prev_reg;
            integral_acc_reg <= integral_next;
            prev_output_reg  <= result_next;
        end
    end

endmodule

`default_nettype wire
